[rtl/phl_pkg.sv]
// ----------------------------------------------------------------------------
// phl_pkg
// Shared constants and codes for the plane height lookup block.
// ----------------------------------------------------------------------------
package phl_pkg;

    localparam int MAX_PLANES_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int CFG_W  = 7;
    localparam int SLOT_W = 6;
    localparam int KIND_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FLAT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SLOPE_Z = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SLOPE_X = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

endpackage

[rtl/plane_height_lookup.sv]
// ----------------------------------------------------------------------------
// plane_height_lookup
// Ground plane table with point height query and slope interpolation.
// ----------------------------------------------------------------------------
// Write beat: taken in idle; the block stays ready for the next beat.
// Query beat: n = min(plane_count, MAX_PLANES) slots read through the single
//   RAM port in the scan, then the shared serial multiply/divide unit when a
//   sloped plane of nonzero length decides. A held result stalls the finish
//   state, and no new beat is taken until the query is done.
// Reset (aresetn low, synchronous): control, plane_count and the last flat
//   plane are cleared; table contents are undefined until written.
// ----------------------------------------------------------------------------
module plane_height_lookup
    import phl_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: plane_count
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_W-1:0]             cfg_data,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [SLOT_W-1:0]            s_slot,
    input  logic [KIND_W-1:0]            s_slope_kind,
    input  logic signed [COORD_BITS-1:0] s_x_start,
    input  logic signed [COORD_BITS-1:0] s_x_end,
    input  logic signed [COORD_BITS-1:0] s_y_start,
    input  logic signed [COORD_BITS-1:0] s_y_end,
    input  logic signed [COORD_BITS-1:0] s_z_start,
    input  logic signed [COORD_BITS-1:0] s_z_end,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic signed [COORD_BITS-1:0] s_pos_z,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_new_y,
    output logic                         m_matched,
    output logic [SLOT_W-1:0]            m_flat_slot,
    output logic signed [COORD_BITS-1:0] m_flat_height,
    output logic                         m_saturated
);

    localparam int C  = COORD_BITS;
    localparam int W  = C + 1;                 // magnitude of a coordinate difference
    localparam int PW = 2 * W;
    localparam int RW = PW + 2;                // signed room for ye +/- q
    localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = AW + 1;                // scan counter, can hold MAX_PLANES
    localparam int DW = KIND_W + 6 * C;        // one table row

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_MUL, ST_FINISH} state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     count_reg;
    logic [CW-1:0]        addr_reg;
    logic [CW-1:0]        n_reg;
    logic                 rd_pend_reg;
    logic [CW-1:0]        idx_pend_reg;
    logic signed [C-1:0]  px_reg, py_reg, pz_reg;

    // last matching plane seen in the scan
    logic                 hit_reg;
    logic                 hit_flat_reg;
    logic                 hit_up_reg;     // y_start above y_end
    logic signed [C-1:0]  hit_y_reg;      // y_start if flat, else y_end
    logic [W-1:0]         hit_h_reg, hit_d_reg, hit_l_reg;

    logic [SLOT_W-1:0]    flat_slot_reg;
    logic signed [C-1:0]  flat_height_reg;

    logic signed [C-1:0]  res_y_reg;
    logic                 res_sat_reg;

    logic                 m_valid_reg;
    logic signed [C-1:0]  m_new_y_reg;
    logic                 m_matched_reg;
    logic [SLOT_W-1:0]    m_flat_slot_reg;
    logic signed [C-1:0]  m_flat_height_reg;
    logic                 m_saturated_reg;

    // ---------------- handshakes ----------------
    logic s_accept;
    logic issue;
    logic scan_end;
    logic out_load;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign issue     = (state_reg == ST_SCAN) && (addr_reg < n_reg);
    assign scan_end  = (state_reg == ST_SCAN) && !issue && !rd_pend_reg;
    // output register free (or freeing this cycle)
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // ---------------- plane table ----------------
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    assign ram_we    = s_accept && (s_op == OP_WRITE) && (32'(s_slot) < MAX_PLANES);
    assign ram_addr  = (state_reg == ST_IDLE) ? AW'(s_slot) : addr_reg[AW-1:0];
    assign ram_wdata = {s_slope_kind, s_x_start, s_x_end, s_y_start,
                        s_y_end, s_z_start, s_z_end};

    phl_ram #(.WIDTH(DW), .DEPTH(MAX_PLANES), .AW(AW)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // row fields
    logic [KIND_W-1:0]   r_kind;
    logic signed [C-1:0] r_xlo, r_xhi, r_yf, r_ys, r_zlo, r_zhi;
    assign r_kind = ram_rdata[DW-1 -: KIND_W];
    assign r_xlo  = ram_rdata[6*C-1 -: C];
    assign r_xhi  = ram_rdata[5*C-1 -: C];
    assign r_yf   = ram_rdata[4*C-1 -: C];
    assign r_ys   = ram_rdata[3*C-1 -: C];
    assign r_zlo  = ram_rdata[2*C-1 -: C];
    assign r_zhi  = ram_rdata[C-1:0];

    // containment test, inclusive bounds
    logic r_hit;
    assign r_hit = rd_pend_reg && (r_kind != KIND_UNUSED)
                && (pz_reg <= r_zhi) && (pz_reg >= r_zlo)
                && (px_reg <= r_xhi) && (px_reg >= r_xlo);

    // slope terms: the axis follows the plane kind
    logic signed [C-1:0] ax_s, ax_e, ax_p;
    logic signed [C:0]   dif_h, dif_d, dif_l;
    logic [W-1:0]        abs_h, abs_d, abs_l;
    always_comb begin
        if (r_kind == KIND_SLOPE_Z) begin
            ax_s = r_zlo;
            ax_e = r_zhi;
            ax_p = pz_reg;
        end else begin
            ax_s = r_xlo;
            ax_e = r_xhi;
            ax_p = px_reg;
        end
        dif_h = {r_yf[C-1], r_yf} - {r_ys[C-1], r_ys};
        dif_d = {ax_p[C-1], ax_p} - {ax_e[C-1], ax_e};
        dif_l = {ax_s[C-1], ax_s} - {ax_e[C-1], ax_e};
        abs_h = dif_h[C] ? W'(-dif_h) : W'(dif_h);
        abs_d = dif_d[C] ? W'(-dif_d) : W'(dif_d);
        abs_l = dif_l[C] ? W'(-dif_l) : W'(dif_l);
    end

    // ---------------- shared multiply/divide ----------------
    logic           md_start;
    logic           md_done;
    logic [PW-1:0]  md_q;
    assign md_start = scan_end && hit_reg && !hit_flat_reg && (hit_l_reg != '0);

    phl_muldiv #(.W(W)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (hit_h_reg),
        .b       (hit_d_reg),
        .c       (hit_l_reg),
        .done    (md_done),
        .q       (md_q)
    );

    // y_end +/- q, clipped to the coordinate range
    localparam logic signed [RW-1:0] Y_MAX = RW'((64'sd1 <<< (C - 1)) - 1);
    localparam logic signed [RW-1:0] Y_MIN = -Y_MAX - 1;
    logic signed [RW-1:0] ye_ext, q_ext, r_sum;
    assign ye_ext = RW'(hit_y_reg);
    assign q_ext  = {2'b00, md_q};
    assign r_sum  = hit_up_reg ? (ye_ext + q_ext) : (ye_ext - q_ext);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            flat_slot_reg   <= '0;
            flat_height_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            rd_pend_reg  <= issue;
            idx_pend_reg <= addr_reg;

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_op == OP_QUERY)) begin
                        px_reg   <= s_pos_x;
                        py_reg   <= s_pos_y;
                        pz_reg   <= s_pos_z;
                        addr_reg <= '0;
                        hit_reg  <= 1'b0;
                        if (32'(count_reg) > MAX_PLANES) begin
                            n_reg <= CW'(MAX_PLANES);
                        end else begin
                            n_reg <= CW'(count_reg);
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    if (r_hit) begin
                        hit_reg      <= 1'b1;
                        hit_flat_reg <= (r_kind == KIND_FLAT);
                        hit_up_reg   <= (r_yf > r_ys);
                        hit_y_reg    <= (r_kind == KIND_FLAT) ? r_yf : r_ys;
                        hit_h_reg    <= abs_h;
                        hit_d_reg    <= abs_d;
                        hit_l_reg    <= abs_l;
                        if (r_kind == KIND_FLAT) begin
                            flat_slot_reg   <= SLOT_W'(idx_pend_reg);
                            flat_height_reg <= r_yf;
                        end
                    end
                    if (scan_end) begin
                        res_sat_reg <= 1'b0;
                        if (!hit_reg) begin
                            res_y_reg <= py_reg;
                            state_reg <= ST_FINISH;
                        end else if (md_start) begin
                            state_reg <= ST_MUL;
                        end else begin
                            // flat plane, or slope of zero length
                            res_y_reg <= hit_y_reg;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_MUL: begin
                    if (md_done) begin
                        if (r_sum > Y_MAX) begin
                            res_y_reg   <= C'(Y_MAX);
                            res_sat_reg <= 1'b1;
                        end else if (r_sum < Y_MIN) begin
                            res_y_reg   <= C'(Y_MIN);
                            res_sat_reg <= 1'b1;
                        end else begin
                            res_y_reg <= C'(r_sum);
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        m_new_y_reg       <= res_y_reg;
                        m_matched_reg     <= hit_reg;
                        m_flat_slot_reg   <= flat_slot_reg;
                        m_flat_height_reg <= flat_height_reg;
                        m_saturated_reg   <= res_sat_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_new_y       = m_new_y_reg;
    assign m_matched     = m_matched_reg;
    assign m_flat_slot   = m_flat_slot_reg;
    assign m_flat_height = m_flat_height_reg;
    assign m_saturated   = m_saturated_reg;

    // ---------------- checks ----------------
    a_sat_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_saturated || m_matched))
        else $error("saturated result without a matching plane");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_SCAN)
        else $error("table read outside scan");

    a_md_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> state_reg == ST_MUL)
        else $error("interpolation finished outside its state");

endmodule

[rtl/phl_ram.sv]
// ----------------------------------------------------------------------------
// phl_ram
// Generic single-port RAM, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module phl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/phl_muldiv.sv]
// ----------------------------------------------------------------------------
// phl_muldiv
// Serial floor(a * b / c): shift-add multiply, then restoring divide.
// ----------------------------------------------------------------------------
module phl_muldiv #(
    parameter int W = 25
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    input  logic [W-1:0]   c,
    output logic           done,
    output logic [2*W-1:0] q
);

    localparam int PW = 2 * W;
    localparam int NW = $clog2(PW + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} phase_t;

    phase_t          phase_reg;
    logic [NW-1:0]   cnt_reg;
    logic [PW-1:0]   mcand_reg;   // shifted multiplicand
    logic [W-1:0]    mplier_reg;
    logic [PW-1:0]   pq_reg;      // product, then quotient shifting in
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    div_reg;
    logic            done_reg;
    logic [W:0]      trial;
    logic [W:0]      trial_sub;

    assign trial     = {rem_reg, pq_reg[PW-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE: begin
                    if (start) begin
                        mcand_reg  <= PW'(a);
                        mplier_reg <= b;
                        div_reg    <= c;
                        pq_reg     <= '0;
                        rem_reg    <= '0;
                        cnt_reg    <= NW'(W);
                        phase_reg  <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    if (mplier_reg[0]) begin
                        pq_reg <= pq_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == NW'(1)) begin
                        cnt_reg   <= NW'(PW);
                        phase_reg <= PH_DIV;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                PH_DIV: begin
                    if (!trial_sub[W]) begin
                        rem_reg <= trial_sub[W-1:0];
                        pq_reg  <= {pq_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[W-1:0];
                        pq_reg  <= {pq_reg[PW-2:0], 1'b0};
                    end
                    if (cnt_reg == NW'(1)) begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign q    = pq_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> phase_reg == PH_IDLE)
        else $error("muldiv started while busy");

    a_done_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(phase_reg) == PH_DIV)
        else $error("muldiv done without divide");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> c != '0)
        else $error("muldiv started with zero divisor");

endmodule

[bench/phl_checker.sv]
// ----------------------------------------------------------------------------
// phl_checker
// Watches the config, input and result channels of plane_height_lookup,
// keeps its own plane table, predicts each query's result and compares.
// ----------------------------------------------------------------------------
module phl_checker
    import phl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_op,
    input  logic [SLOT_W-1:0]        s_slot,
    input  logic [KIND_W-1:0]        s_slope_kind,
    input  logic signed [23:0]       s_x_start,
    input  logic signed [23:0]       s_x_end,
    input  logic signed [23:0]       s_y_start,
    input  logic signed [23:0]       s_y_end,
    input  logic signed [23:0]       s_z_start,
    input  logic signed [23:0]       s_z_end,
    input  logic signed [23:0]       s_pos_x,
    input  logic signed [23:0]       s_pos_y,
    input  logic signed [23:0]       s_pos_z,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [23:0]       m_new_y,
    input  logic                     m_matched,
    input  logic [SLOT_W-1:0]        m_flat_slot,
    input  logic signed [23:0]       m_flat_height,
    input  logic                     m_saturated,
    output int                       fail_count,
    output int                       heights_pending,
    output int                       query_count,
    output int                       hit_count
);

    localparam int NPL = MAX_PLANES_DEF;

    typedef struct {
        logic signed [23:0] y;
        logic               hit;
        logic [SLOT_W-1:0]  fslot;
        logic signed [23:0] fheight;
        logic               sat;
    } height_t;

    logic [KIND_W-1:0]  tbl_kind [NPL];
    logic signed [23:0] tbl_xl [NPL], tbl_xh [NPL], tbl_zl [NPL], tbl_zh [NPL];
    logic signed [23:0] tbl_y0 [NPL], tbl_y1 [NPL];
    logic [CFG_W-1:0]   n_planes;
    logic [SLOT_W-1:0]  flat_slot_q;
    logic signed [23:0] flat_height_q;
    height_t            heights_q [$];

    function automatic longint unsigned abs_diff(longint a, longint b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // linear ramp from y_end at the end edge to y_start at the start edge
    function automatic logic signed [23:0] ramp(longint ys, longint ye, longint s,
                                                longint e, longint p, output logic sat);
        longint unsigned span, q;
        longint r;
        sat = 1'b0;
        span = abs_diff(s, e);
        if (span == 0) return ye[23:0];
        q = (abs_diff(ys, ye) * abs_diff(p, e)) / span;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        r = (ys > ye) ? ye + longint'(q) : ye - longint'(q);
        if (r > 64'sd8388607)  begin r = 64'sd8388607;  sat = 1'b1; end
        if (r < -64'sd8388608) begin r = -64'sd8388608; sat = 1'b1; end
        return r[23:0];
    endfunction

    function automatic height_t lookup_height(logic signed [23:0] px,
                                              logic signed [23:0] py,
                                              logic signed [23:0] pz);
        height_t h;
        int      n;
        logic    s;
        h.y = py; h.hit = 1'b0; h.sat = 1'b0;
        n = (n_planes > NPL) ? NPL : n_planes;
        for (int i = 0; i < n; i++) begin
            if (tbl_kind[i] == KIND_UNUSED) continue;
            if (pz > tbl_zh[i] || pz < tbl_zl[i] || px > tbl_xh[i] || px < tbl_xl[i])
                continue;
            h.hit = 1'b1;
            case (tbl_kind[i])
                KIND_FLAT: begin
                    h.y = tbl_y0[i];
                    h.sat = 1'b0;
                    flat_slot_q = i[SLOT_W-1:0];
                    flat_height_q = tbl_y0[i];
                end
                KIND_SLOPE_Z: begin
                    h.y = ramp(tbl_y0[i], tbl_y1[i], tbl_zl[i], tbl_zh[i], pz, s);
                    h.sat = s;
                end
                default: begin
                    h.y = ramp(tbl_y0[i], tbl_y1[i], tbl_xl[i], tbl_xh[i], px, s);
                    h.sat = s;
                end
            endcase
        end
        h.fslot = flat_slot_q;
        h.fheight = flat_height_q;
        return h;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        heights_pending = 0;
        query_count = 0;
        hit_count = 0;
    end

    always @(posedge aclk) begin
        height_t h;
        if (!aresetn) begin
            n_planes <= '0;
            flat_slot_q = '0;
            flat_height_q = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (heights_q.size() == 0) begin
                    report("unexpected result beat", 1, 0);
                end else begin
                    h = heights_q.pop_front();
                    if (m_new_y !== h.y)             report("new_y", m_new_y, h.y);
                    if (m_matched !== h.hit)         report("matched", m_matched, h.hit);
                    if (m_flat_slot !== h.fslot)     report("flat_slot", m_flat_slot, h.fslot);
                    if (m_flat_height !== h.fheight)
                        report("flat_height", m_flat_height, h.fheight);
                    if (m_saturated !== h.sat)       report("saturated", m_saturated, h.sat);
                end
            end
            if (cfg_valid && cfg_ready) n_planes <= cfg_data;
            if (s_valid && s_ready) begin
                if (s_op == OP_WRITE) begin
                    tbl_kind[s_slot] <= s_slope_kind;
                    tbl_xl[s_slot] <= s_x_start;
                    tbl_xh[s_slot] <= s_x_end;
                    tbl_y0[s_slot] <= s_y_start;
                    tbl_y1[s_slot] <= s_y_end;
                    tbl_zl[s_slot] <= s_z_start;
                    tbl_zh[s_slot] <= s_z_end;
                end else begin
                    h = lookup_height(s_pos_x, s_pos_y, s_pos_z);
                    heights_q.push_back(h);
                    query_count++;
                    if (h.hit) hit_count++;
                end
            end
            heights_pending = heights_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for plane_height_lookup: directed planes and queries,
// then random plane tables queried under several plane counts, with random
// gaps and stalls on both channels. Checking lives in phl_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import phl_pkg::*;

    localparam int NPL       = MAX_PLANES_DEF;
    localparam int QUIET_MAX = 3000;   // cycles with no beat before giving up
    localparam int DRAIN     = 200;    // longer than one full scan plus divide
    localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN = -24'sh800000;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic s_valid, s_ready, s_op;
    logic [SLOT_W-1:0] s_slot;
    logic [KIND_W-1:0] s_slope_kind;
    logic signed [23:0] s_x_start, s_x_end, s_y_start, s_y_end, s_z_start, s_z_end;
    logic signed [23:0] s_pos_x, s_pos_y, s_pos_z;
    logic m_valid, m_ready, m_matched, m_saturated;
    logic signed [23:0] m_new_y, m_flat_height;
    logic [SLOT_W-1:0] m_flat_slot;

    int fail_count, heights_pending, query_count, hit_count;
    int quiet_cycles;
    int stall_mode;   // 0: result side always ready, 1: random stalls
    bit gaps_on;

    // shadow of rectangle bounds, used only to aim query points at planes
    logic signed [23:0] sh_xl [NPL], sh_xh [NPL], sh_zl [NPL], sh_zh [NPL];
    int scan_n;

    plane_height_lookup u_dut (.*);

    phl_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: stalls mostly short, a few long, some stretches none
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_mode == 0 || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3))
                    @(posedge aclk);
            end
        end
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("watchdog: no beat for %0d cycles", QUIET_MAX);
            $display("plane_height_lookup verification failed");
            $finish;
        end
    end

    function automatic logic signed [23:0] rnd24();
        return 24'($urandom());
    endfunction

    // sender gap, then present one beat and hold it until accepted
    task automatic send_beat(logic op, logic [SLOT_W-1:0] slot, logic [KIND_W-1:0] kind,
                             logic signed [23:0] xs, logic signed [23:0] xe,
                             logic signed [23:0] ys, logic signed [23:0] ye,
                             logic signed [23:0] zs, logic signed [23:0] ze,
                             logic signed [23:0] px, logic signed [23:0] py,
                             logic signed [23:0] pz);
        int gap;
        gap = !gaps_on ? 0 : ($urandom_range(0, 15) == 0 ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op; s_slot <= slot; s_slope_kind <= kind;
        s_x_start <= xs; s_x_end <= xe; s_y_start <= ys; s_y_end <= ye;
        s_z_start <= zs; s_z_end <= ze;
        s_pos_x <= px; s_pos_y <= py; s_pos_z <= pz;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_WRITE) begin
            sh_xl[slot] = xs; sh_xh[slot] = xe; sh_zl[slot] = zs; sh_zh[slot] = ze;
        end
    endtask

    task automatic put_plane(int slot, logic [KIND_W-1:0] kind,
                             logic signed [23:0] xs, logic signed [23:0] xe,
                             logic signed [23:0] ys, logic signed [23:0] ye,
                             logic signed [23:0] zs, logic signed [23:0] ze);
        send_beat(OP_WRITE, SLOT_W'(slot), kind, xs, xe, ys, ye, zs, ze,
                  rnd24(), rnd24(), rnd24());
    endtask

    task automatic ask_height(logic signed [23:0] px, logic signed [23:0] py,
                              logic signed [23:0] pz);
        send_beat(OP_QUERY, SLOT_W'($urandom()), KIND_W'($urandom()), rnd24(), rnd24(),
                  rnd24(), rnd24(), rnd24(), rnd24(), px, py, pz);
    endtask

    // plane_count only changes with nothing in flight; writes give no result,
    // so also sit out the longest possible busy time
    task automatic set_plane_count(int n);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (heights_pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(n);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_n = (n > NPL) ? NPL : n;
    endtask

    // random bounds pair: mostly small ordered spans, some wide, some inverted
    task automatic rnd_span(output logic signed [23:0] lo, output logic signed [23:0] hi);
        longint a, b;
        int pick;
        pick = $urandom_range(0, 19);
        a = rnd24();
        if (pick < 14) begin
            b = a + $urandom_range(0, pick < 7 ? 4095 : 1 << 20);
            if (b > CMAX) b = CMAX;
        end else if (pick < 16) begin
            b = a;
        end else if (pick < 17) begin
            b = a - $urandom_range(1, 1000);
            if (b < CMIN) b = CMIN;
        end else begin
            b = rnd24();
        end
        lo = a[23:0];
        hi = b[23:0];
    endtask

    task automatic rnd_plane(int slot);
        logic signed [23:0] xl, xh, zl, zh;
        logic [KIND_W-1:0] kind;
        rnd_span(xl, xh);
        rnd_span(zl, zh);
        kind = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : KIND_W'($urandom_range(0, 2));
        put_plane(slot, kind, xl, xh, rnd24(), rnd24(), zl, zh);
    endtask

    function automatic logic signed [23:0] pick_in(longint lo, longint hi);
        if (hi < lo) return rnd24();
        case ($urandom_range(0, 4))
            0: return lo[23:0];
            1: return hi[23:0];
            default: return 24'(lo + ($urandom() % (hi - lo + 1)));
        endcase
    endfunction

    task automatic rnd_query();
        int s;
        if (scan_n > 0 && $urandom_range(0, 9) < 8) begin
            s = $urandom_range(0, scan_n - 1);
            ask_height(pick_in(sh_xl[s], sh_xh[s]), rnd24(), pick_in(sh_zl[s], sh_zh[s]));
        end else begin
            ask_height(rnd24(), rnd24(), rnd24());
        end
    endtask

    initial begin
        int counts [6];
        cfg_valid = 1'b0; cfg_data = '0;
        s_valid = 1'b0; s_op = OP_WRITE; s_slot = '0; s_slope_kind = KIND_FLAT;
        s_x_start = '0; s_x_end = '0; s_y_start = '0; s_y_end = '0;
        s_z_start = '0; s_z_end = '0; s_pos_x = '0; s_pos_y = '0; s_pos_z = '0;
        quiet_cycles = 0;
        stall_mode = 0;
        gaps_on = 1'b0;
        scan_n = 0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flat floor over the whole space, slopes, unused kind,
        // inverted rectangle, zero-length slope
        put_plane(0, KIND_FLAT, CMIN, CMAX, 24'sd1234, -24'sd9, CMIN, CMAX);
        put_plane(1, KIND_SLOPE_Z, 24'sd0, 24'sd1000, 24'sd5000, -24'sd300,
                  24'sd100, 24'sd2100);
        put_plane(2, KIND_SLOPE_X, -24'sd2000, -24'sd1000, CMIN, CMAX, 24'sd0, 24'sd50);
        put_plane(3, KIND_UNUSED, CMIN, CMAX, 24'sd77, 24'sd77, CMIN, CMAX);
        put_plane(4, KIND_FLAT, 24'sd500, 24'sd400, 24'sd999, 24'sd0, CMIN, CMAX);
        put_plane(5, KIND_SLOPE_X, 24'sd3000, 24'sd3000, 24'sd10, -24'sd20,
                  24'sd3000, 24'sd3000);
        ask_height(24'sd0, 24'sd42, 24'sd0);          // count is 0: pass through
        set_plane_count(6);
        ask_height(24'sd5000, 24'sd1, 24'sd5000);     // only the floor
        ask_height(24'sd500, 24'sd2, 24'sd100);       // z slope start edge
        ask_height(24'sd500, 24'sd3, 24'sd2100);      // z slope end edge
        ask_height(24'sd0, 24'sd4, 24'sd1300);        // z slope middle
        ask_height(-24'sd1500, 24'sd5, 24'sd25);      // x slope, full height swing
        ask_height(-24'sd2000, 24'sd6, 24'sd50);
        ask_height(24'sd450, 24'sd7, 24'sd200000);    // inside inverted x range
        ask_height(24'sd3000, 24'sd8, 24'sd3000);     // zero-length slope
        ask_height(CMAX, CMIN, CMIN);
        ask_height(CMIN, CMAX, CMAX);
        put_plane(0, KIND_UNUSED, CMIN, CMAX, 24'sd0, 24'sd0, CMIN, CMAX);
        ask_height(24'sd1, 24'sd9, 24'sd1);           // nothing matches

        // random: fill the whole table, then sweep plane counts
        gaps_on = 1'b1;
        stall_mode = 1;
        for (int i = 0; i < NPL; i++) rnd_plane(i);
        counts = '{NPL, 0, 1, 127, $urandom_range(2, NPL - 1), NPL};
        for (int ph = 0; ph < 6; ph++) begin
            set_plane_count(counts[ph]);
            stall_mode = ph % 3 == 2 ? 0 : 1;
            gaps_on = ph != 4;
            for (int k = 0; k < 190; k++) begin
                if ($urandom_range(0, 4) == 0) rnd_plane($urandom_range(0, NPL - 1));
                else rnd_query();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (heights_pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        $display("run covered %0d height queries, %0d of them on a plane,", query_count,
                 hit_count);
        $display("with plane counts from 0 to 127 and random stalls on both sides");
        if (fail_count == 0)
            $display("plane_height_lookup verification clean");
        else
            $display("plane_height_lookup verification failed");
        $finish;
    end

endmodule
